// ----- rtl/lh_pkg.sv -----
// ----------------------------------------------------------------------------
// lh_pkg: shared types and constants of the log2 latency histogram
// Holds the field widths, the command and status bundles that join the
// controller and the datapath, and the selector for the query result.
// ----------------------------------------------------------------------------
`default_nettype none

package lh_pkg;

    localparam int LAT_W  = 64;   // latency field and bound field
    localparam int PCT_W  = 7;    // percentile field
    localparam int TOT_W  = 32;   // reported total
    localparam int SEEN_W = 64;   // running sum of the walk, saturating
    localparam int PROD_W = SEEN_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef enum logic [1:0] {
        BOUND_ZERO,
        BOUND_FOUND,
        BOUND_ONES
    } t_bound_sel;

    typedef struct packed {
        logic       load_in;    // capture the accepted item
        logic       enc;        // bucket index from the latency
        logic       rd;         // read the bucket at the current index
        logic       wr_obs;     // write back the incremented bucket, count up
        logic       q_init;     // start a walk: target, running sum, index
        logic       acc;        // add the bucket read to the running sum
        logic       mul;        // scale the running sum by one hundred
        logic       step_idx;   // move to the next bucket
        logic       set_bound;  // load the bound register
        t_bound_sel bound_sel;
        logic       load_out;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic kind;       // 1 for a query
        logic q_invalid;  // empty histogram or percentile out of range
        logic hit;        // running sum reaches the wanted count
        logic last;       // index is at the last bucket
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/lh_ctrl.sv -----
// ----------------------------------------------------------------------------
// lh_ctrl: sequencer of the log2 latency histogram
// Steps an observe through a read-modify-write of one bucket and a query
// through a walk over the buckets, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire lh_pkg::t_status i_status,
    output lh_pkg::t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OBS_RD,
        S_OBS_WR,
        S_Q_RD,
        S_Q_ACC,
        S_Q_MUL,
        S_Q_CMP
    } t_state;

    // The done phase is kept apart so the state enum stays dense.
    typedef enum logic {
        P_RUN,
        P_DONE
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;
    logic   out_busy;

    assign out_busy    = r_out_valid && !i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && (r_phase == P_RUN);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.bound_sel = lh_pkg::BOUND_ZERO;
        if (r_phase == P_DONE) begin
            if (!out_busy) begin
                o_cmd.load_out = 1'b1;
                n_out_valid    = 1'b1;
                n_phase        = P_RUN;
                n_state        = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.load_in = 1'b1;
                        n_state       = S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (!i_status.kind) begin
                        o_cmd.enc = 1'b1;
                        n_state   = S_OBS_RD;
                    end else if (i_status.q_invalid) begin
                        o_cmd.set_bound = 1'b1;
                        o_cmd.bound_sel = lh_pkg::BOUND_ZERO;
                        n_phase         = P_DONE;
                    end else begin
                        o_cmd.q_init = 1'b1;
                        n_state      = S_Q_RD;
                    end
                end
                S_OBS_RD: begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_OBS_WR;
                end
                S_OBS_WR: begin
                    o_cmd.wr_obs    = 1'b1;
                    o_cmd.set_bound = 1'b1;
                    o_cmd.bound_sel = lh_pkg::BOUND_ZERO;
                    n_phase         = P_DONE;
                end
                S_Q_RD: begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_Q_ACC;
                end
                S_Q_ACC: begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_Q_MUL;
                end
                S_Q_MUL: begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_Q_CMP;
                end
                S_Q_CMP: begin
                    if (i_status.hit) begin
                        o_cmd.set_bound = 1'b1;
                        o_cmd.bound_sel = lh_pkg::BOUND_FOUND;
                        n_phase         = P_DONE;
                    end else if (i_status.last) begin
                        o_cmd.set_bound = 1'b1;
                        o_cmd.bound_sel = lh_pkg::BOUND_ONES;
                        n_phase         = P_DONE;
                    end else begin
                        o_cmd.step_idx = 1'b1;
                        n_state        = S_Q_RD;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lh_datapath.sv -----
// ----------------------------------------------------------------------------
// lh_datapath: bucket store and arithmetic of the log2 latency histogram
// Holds the bucket memory with its valid bits, the total count, the bucket
// index encoder, the running sum of a query walk and the output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_datapath #(
    parameter int NUM_BUCKETS  = 64,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_kind,
    input  wire logic [lh_pkg::LAT_W-1:0]      i_latency_ns,
    input  wire logic [lh_pkg::PCT_W-1:0]      i_percentile_wanted,
    input  wire lh_pkg::t_cmd                  i_cmd,
    output lh_pkg::t_status                    o_status,
    output logic      [lh_pkg::LAT_W-1:0]      o_percentile_bound,
    output logic      [lh_pkg::TOT_W-1:0]      o_total_observed
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);
    localparam logic [5:0]       LAST_ENC = 6'(NUM_BUCKETS - 1);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    // Highest set bit of a 64-bit word in two levels of eight: first the
    // highest nonzero byte, then the highest bit inside it. Zero gives zero.
    function automatic logic [5:0] msb_pos(input logic [63:0] v);
        logic [7:0] grp;
        logic [2:0] hg;
        logic [2:0] hb;
        logic [7:0] byte_v;
        grp = '0;
        hg  = '0;
        hb  = '0;
        for (int k = 0; k < 8; k++) begin
            grp[k] = |v[8*k +: 8];
        end
        for (int k = 0; k < 8; k++) begin
            if (grp[k]) begin
                hg = 3'(k);
            end
        end
        byte_v = v[8*hg +: 8];
        for (int k = 0; k < 8; k++) begin
            if (byte_v[k]) begin
                hb = 3'(k);
            end
        end
        return {hg, hb};
    endfunction

    logic                     r_kind;
    logic [lh_pkg::LAT_W-1:0] r_lat;
    logic [lh_pkg::PCT_W-1:0] r_pct;
    logic [IDX_W-1:0]         r_idx;
    logic [COUNTER_BITS-1:0]  r_total;
    logic [COUNTER_BITS-1:0]  r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0]   r_valid;
    logic [COUNTER_BITS-1:0]  r_rd_data;
    logic                     r_rd_valid;
    logic [lh_pkg::SEEN_W-1:0] r_seen;
    logic [lh_pkg::PROD_W-1:0] r_seen100;
    logic [lh_pkg::PROD_W-1:0] r_target;
    logic [lh_pkg::LAT_W-1:0]  r_bound;
    logic [lh_pkg::LAT_W-1:0]  r_out_bound;
    logic [lh_pkg::TOT_W-1:0]  r_out_total;

    logic [5:0]                msb;
    logic [5:0]                enc_idx;
    logic [COUNTER_BITS-1:0]   rd_eff;
    logic [COUNTER_BITS-1:0]   rd_inc;
    logic [COUNTER_BITS-1:0]   total_inc;
    logic [lh_pkg::SEEN_W:0]   seen_sum;
    logic [63:0]               total64;
    logic [6:0]                shamt;
    logic [lh_pkg::LAT_W-1:0]  found_bound;

    assign msb     = msb_pos(r_lat);
    assign enc_idx = (msb >= LAST_ENC) ? LAST_ENC : msb;

    // A bucket never written reads as zero.
    assign rd_eff    = r_rd_valid ? r_rd_data : '0;
    assign rd_inc    = (rd_eff == CTR_MAX) ? CTR_MAX : rd_eff + 1'b1;
    assign total_inc = (r_total == CTR_MAX) ? CTR_MAX : r_total + 1'b1;
    assign seen_sum  = {1'b0, r_seen} + (lh_pkg::SEEN_W + 1)'(rd_eff);
    assign total64   = 64'(r_total);

    assign shamt       = 7'(r_idx) + 7'd1;
    assign found_bound = (r_idx == LAST_IDX) ? '1 : ~({lh_pkg::LAT_W{1'b1}} << shamt);

    assign o_status.kind      = r_kind;
    assign o_status.q_invalid = (r_total == '0) || (r_pct == '0) || (r_pct > lh_pkg::PCT_MAX);
    assign o_status.hit       = (r_seen100 >= r_target);
    assign o_status.last      = (r_idx == LAST_IDX);

    assign o_percentile_bound = r_out_bound;
    assign o_total_observed   = r_out_total;

    // Bucket memory: one read or one write per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
        if (i_cmd.wr_obs) begin
            r_mem[r_idx] <= rd_inc;
        end
    end

    // Control state: valid bits and the total count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_total    <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_valid <= r_valid[r_idx];
            end
            if (i_cmd.wr_obs) begin
                r_valid[r_idx] <= 1'b1;
                r_total        <= total_inc;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
            r_lat  <= i_latency_ns;
            r_pct  <= i_percentile_wanted;
        end
        if (i_cmd.enc) begin
            r_idx <= IDX_W'(enc_idx);
        end else if (i_cmd.q_init) begin
            r_idx <= '0;
        end else if (i_cmd.step_idx) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.q_init) begin
            // The walk stops where 100 * sum reaches count * p, which is the
            // same test as sum reaching ceil(count * p / 100).
            r_target <= lh_pkg::PROD_W'(total64) * lh_pkg::PROD_W'(r_pct);
            r_seen   <= '0;
        end else if (i_cmd.acc) begin
            r_seen <= seen_sum[lh_pkg::SEEN_W] ? '1 : seen_sum[lh_pkg::SEEN_W-1:0];
        end
        if (i_cmd.mul) begin
            r_seen100 <= lh_pkg::PROD_W'(r_seen) * lh_pkg::PROD_W'(lh_pkg::PCT_SCALE);
        end
        if (i_cmd.set_bound) begin
            case (i_cmd.bound_sel)
                lh_pkg::BOUND_ZERO:  r_bound <= '0;
                lh_pkg::BOUND_FOUND: r_bound <= found_bound;
                lh_pkg::BOUND_ONES:  r_bound <= '1;
                default:             r_bound <= '0;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_bound <= r_bound;
            r_out_total <= (|total64[63:32]) ? '1 : total64[31:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/log2_latency_histogram.sv -----
// ----------------------------------------------------------------------------
// log2_latency_histogram: power-of-two latency histogram with percentiles
// Counts observed latencies in buckets floor(log2(latency)) and answers
// percentile queries with the upper bound of the bucket that reaches it.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_ready   i_kind, i_latency_ns,
//                                                i_percentile_wanted
//  out      output     o_out_valid / i_out_ready o_percentile_bound,
//                                                o_total_observed
//
// An observe item is accepted, decoded to its bucket index, read and written
// once on the single memory port, and handed to the output register before
// the next item is accepted. A query that is invalid or finds the histogram
// empty goes from decode straight to the output hand-off; otherwise it walks
// the buckets from the first, visiting 1 to NUM_BUCKETS of them, and each
// bucket costs a read, an add, a scale by one hundred and a compare.
// Reset is synchronous and active low; the bucket store needs no clearing pass,
// since per-bucket valid bits make every bucket read as zero after reset.
// A stalled output holds its item; the block keeps working on the next item
// and waits only when it must hand over a second result.
`default_nettype none

module log2_latency_histogram #(
    parameter int NUM_BUCKETS  = 64,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_kind,
    input  wire logic [lh_pkg::LAT_W-1:0] i_latency_ns,
    input  wire logic [lh_pkg::PCT_W-1:0] i_percentile_wanted,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic      [lh_pkg::LAT_W-1:0] o_percentile_bound,
    output logic      [lh_pkg::TOT_W-1:0] o_total_observed
);

    // Commands from the sequencer and status back from the datapath are the
    // only connection between the two halves.
    lh_pkg::t_cmd    cmd;
    lh_pkg::t_status status;

    lh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the bucket memory, the total count, the running sum
    // of a walk and the output registers that the out channel shows.
    lh_datapath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_kind              (i_kind),
        .i_latency_ns        (i_latency_ns),
        .i_percentile_wanted (i_percentile_wanted),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_percentile_bound  (o_percentile_bound),
        .o_total_observed    (o_total_observed)
    );

endmodule

`default_nettype wire

// ----- rtl/lh_checker.sv -----
// ----------------------------------------------------------------------------
// lh_checker: port-level checks of the log2 latency histogram
// Watches the top-level ports and flags results or handshakes that the block
// can never produce.
// ----------------------------------------------------------------------------
`default_nettype none

module lh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_percentile_bound,
    input wire logic [31:0] o_total_observed
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_percentile_bound) && $stable(o_total_observed))
        else $error("stalled result changed");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // A new result is only handed over while no item is being taken in.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without an item at work");

    // Every bound is zero or a run of ones from bit zero up.
    a_bound_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_percentile_bound & (o_percentile_bound + 64'd1)) == 64'd0))
        else $error("bound is not of the form 2^k-1");

endmodule

bind log2_latency_histogram lh_checker u_lh_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_percentile_bound  (o_percentile_bound),
    .o_total_observed    (o_total_observed)
);

`default_nettype wire
